>>> design/scmoc_pkg.sv
// ----------------------------------------------------------------------------
// scmoc_pkg
// Shared constants for the scan minimum and object counter: field widths,
// register indexes, reset values and fixed limits.
// ----------------------------------------------------------------------------
package scmoc_pkg;

    // field widths
    localparam int ANGLE_W = 15;
    localparam int DIST_W  = 16;
    localparam int MIN_W   = 17;
    localparam int COUNT_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PHASE_W = 3;

    // default ring size
    localparam int RING_DEPTH_DEF = 128;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_END      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD = 2'd2;

    // register reset values
    localparam logic [ANGLE_W-1:0] ANGLE_START_RST    = 15'd0;
    localparam logic [ANGLE_W-1:0] ANGLE_END_RST      = 15'd23040;
    localparam logic [DIST_W-1:0]  NEAR_THRESHOLD_RST = 16'd1000;

    // minimum search marker for "nothing seen"
    localparam logic [MIN_W-1:0] NO_MIN = 17'd100000;

    // every fifth point is stored if it is in the window: phase runs 0..4
    localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd4;

    // object count saturates here
    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

endpackage

>>> design/scan_min_and_object_counter_top.sv
// ----------------------------------------------------------------------------
// scan_min_and_object_counter_top
// Tracks the nearest in-window point of a rangefinder scan, keeps every fifth
// point, if in window, in a sample ring and counts objects in the ring at each scan start.
// ----------------------------------------------------------------------------
//  channel   | signals                                        | handshake
//  ----------+------------------------------------------------+----------------
//  point in  | start_of_scan, distance_mm, angle_q6           | start & !busy
//  result    | object_count, nearest_distance, nearest_angle  | done, 1 cycle
//  config    | cfg_index, cfg_data                            | cfg_we
//
//  an ordinary point is taken on its accepting edge; busy stays low and the next point
//  may follow in the next cycle
//  a start-of-scan point walks the ring through the memory read port, one
//  entry a cycle: done rises once the last entry read has passed the detector
//  after reset a clearing pass writes zero to every ring entry with busy
//  high; configuration writes are taken throughout
//  the receiver cannot stall: done is high for exactly one cycle per result
// ----------------------------------------------------------------------------
module scan_min_and_object_counter_top
    import scmoc_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // point transaction
    input  logic                  start,
    output logic                  busy,
    input  logic                  start_of_scan,
    input  logic [DIST_W-1:0]     distance_mm,
    input  logic [ANGLE_W-1:0]    angle_q6,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // result transaction
    output logic                  done,
    output logic [COUNT_W-1:0]    object_count,
    output logic [MIN_W-1:0]      nearest_distance,
    output logic [ANGLE_W-1:0]    nearest_angle
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);
    localparam logic [AW:0]   WALK_END  = (AW+1)'(RING_DEPTH);
    localparam logic [AW:0]   WALK_LAST = (AW+1)'(RING_DEPTH - 1);

    // control states
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [ANGLE_W-1:0] angle_start_reg;
    logic [ANGLE_W-1:0] angle_end_reg;
    logic [DIST_W-1:0]  near_thr_reg;

    logic [MIN_W-1:0]   min_reg, min_next;
    logic [ANGLE_W-1:0] min_angle_reg, min_angle_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [AW-1:0]      ring_idx_reg, ring_idx_next;

    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [AW:0]        walk_cnt_reg, walk_cnt_next;
    logic               rd_vld_reg, rd_vld_next;
    logic               rd_last_reg, rd_last_next;
    logic [DIST_W-1:0]  rd_data_reg;

    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               wait_empty_reg, wait_empty_next;
    logic               done_reg, done_next;
    logic [COUNT_W-1:0] obj_cnt_reg, obj_cnt_next;
    logic [MIN_W-1:0]   res_dist_reg, res_dist_next;
    logic [ANGLE_W-1:0] res_angle_reg, res_angle_next;

    logic               accept;
    logic               in_window;
    logic               pt_we;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [DIST_W-1:0]  mem_wdata;
    logic               mem_re;

    logic [DIST_W-1:0]  ring_mem [RING_DEPTH];

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_start_reg <= ANGLE_START_RST;
            angle_end_reg   <= ANGLE_END_RST;
            near_thr_reg    <= NEAR_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ANGLE_START:    angle_start_reg <= cfg_data[ANGLE_W-1:0];
                REG_ANGLE_END:      angle_end_reg   <= cfg_data[ANGLE_W-1:0];
                REG_NEAR_THRESHOLD: near_thr_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    // window test and point store decision
    assign in_window = (angle_q6 >= angle_start_reg) && (angle_q6 < angle_end_reg);
    assign pt_we     = accept && !start_of_scan && in_window && (phase_reg == PHASE_LAST);

    // memory port selection: clearing pass or point store on write, walk on read
    assign mem_we    = (state_reg == ST_CLEAR) || pt_we;
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : ring_idx_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : distance_mm;
    assign mem_re    = (state_reg == ST_WALK) && (walk_cnt_reg != WALK_END);

    // sample ring memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= ring_mem[walk_cnt_reg[AW-1:0]];
        end
    end

    // next state logic
    always_comb
    begin
        state_next      = state_reg;
        min_next        = min_reg;
        min_angle_next  = min_angle_reg;
        phase_next      = phase_reg;
        ring_idx_next   = ring_idx_reg;
        clr_cnt_next    = clr_cnt_reg;
        walk_cnt_next   = walk_cnt_reg;
        rd_vld_next     = mem_re;
        rd_last_next    = mem_re && (walk_cnt_reg == WALK_LAST);
        cnt_next        = cnt_reg;
        wait_empty_next = wait_empty_reg;
        done_next       = 1'b0;
        obj_cnt_next    = obj_cnt_reg;
        res_dist_next   = res_dist_reg;
        res_angle_next  = res_angle_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && start_of_scan)
                begin
                    // capture the scan result, restart the scan state
                    res_dist_next   = min_reg;
                    res_angle_next  = min_angle_reg;
                    min_next        = NO_MIN;
                    min_angle_next  = '0;
                    phase_next      = '0;
                    ring_idx_next   = '0;
                    walk_cnt_next   = '0;
                    cnt_next        = '0;
                    wait_empty_next = 1'b0;
                    state_next      = ST_WALK;
                end
                else if (accept)
                begin
                    phase_next = (phase_reg == PHASE_LAST) ? '0 : phase_reg + 1'b1;
                    if (in_window && (distance_mm != '0)
                        && ({1'b0, distance_mm} < min_reg))
                    begin
                        min_next       = {1'b0, distance_mm};
                        min_angle_next = angle_q6;
                    end
                    if (pt_we)
                    begin
                        ring_idx_next = (ring_idx_reg == LAST_ADDR) ? '0
                                                                    : ring_idx_reg + 1'b1;
                    end
                end
            end
            ST_WALK:
            begin
                if (mem_re)
                begin
                    walk_cnt_next = walk_cnt_reg + 1'b1;
                end
                // two-state detector over the returned entry
                if (rd_vld_reg)
                begin
                    if (!wait_empty_reg && (rd_data_reg < near_thr_reg))
                    begin
                        if (cnt_reg != COUNT_MAX)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                        wait_empty_next = 1'b1;
                    end
                    else if (wait_empty_reg && (rd_data_reg > near_thr_reg))
                    begin
                        wait_empty_next = 1'b0;
                    end
                    if (rd_last_reg)
                    begin
                        obj_cnt_next = cnt_next;
                        done_next    = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            min_reg        <= NO_MIN;
            min_angle_reg  <= '0;
            phase_reg      <= '0;
            ring_idx_reg   <= '0;
            clr_cnt_reg    <= '0;
            walk_cnt_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            rd_last_reg    <= 1'b0;
            cnt_reg        <= '0;
            wait_empty_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            min_reg        <= min_next;
            min_angle_reg  <= min_angle_next;
            phase_reg      <= phase_next;
            ring_idx_reg   <= ring_idx_next;
            clr_cnt_reg    <= clr_cnt_next;
            walk_cnt_reg   <= walk_cnt_next;
            rd_vld_reg     <= rd_vld_next;
            rd_last_reg    <= rd_last_next;
            cnt_reg        <= cnt_next;
            wait_empty_reg <= wait_empty_next;
            done_reg       <= done_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        obj_cnt_reg   <= obj_cnt_next;
        res_dist_reg  <= res_dist_next;
        res_angle_reg <= res_angle_next;
    end

    assign done             = done_reg;
    assign object_count     = obj_cnt_reg;
    assign nearest_distance = res_dist_reg;
    assign nearest_angle    = res_angle_reg;

`ifndef SYNTHESIS
    // a result only ever closes a ring walk
    a_done_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_WALK) && (state_reg == ST_IDLE))
        else $error("result without a completed ring walk");

    // no point store while the clearing pass owns the write port
    a_no_store_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !pt_we)
        else $error("point store during clearing pass");

    // returned read data only arrives inside a walk
    a_read_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == ST_WALK))
        else $error("read data outside ring walk");

    // a start-of-scan point always launches a walk from entry zero
    a_sos_walks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && start_of_scan) |=> (state_reg == ST_WALK) && (walk_cnt_reg == '0))
        else $error("start of scan did not start the ring walk");

    // the detector count never runs past saturation
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_vld_reg && (cnt_reg == COUNT_MAX)) |=> (cnt_reg == COUNT_MAX))
        else $error("object count wrapped");
`endif

endmodule
